FILE: rtl/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg: shared types and constants for the mask wipe alpha block
// Field widths, configuration register indexes, pipeline payload structs.
// ----------------------------------------------------------------------------
package mta_pkg;

  // Mask store size and coordinate width
  localparam int MASK_TEXELS  = 65536;
  localparam int COORD_BITS   = 12;
  localparam int MASK_AW      = $clog2(MASK_TEXELS);

  // Field and register widths
  localparam int SIZE_W       = 13;
  localparam int PROG_W       = 9;
  localparam int LD_ADDR_W    = 16;
  localparam int TEXEL_W      = 8;
  localparam int PIXEL_W      = 12;
  localparam int ALPHA_W      = 8;
  localparam int CFG_AW       = 3;

  // Input word layout, lowest field first
  localparam int IN_TDATA_W   = 48;
  localparam int LD_ADDR_LO   = 0;
  localparam int LD_VAL_LO    = LD_ADDR_LO + LD_ADDR_W;
  localparam int PIX_X_LO     = LD_VAL_LO + TEXEL_W;
  localparam int PIX_Y_LO     = PIX_X_LO + PIXEL_W;

  // Scaling divider widths
  localparam int PROD_W       = COORD_BITS + SIZE_W;
  localparam int QUO_W        = SIZE_W;
  localparam int CMP_W        = (PROD_W > SIZE_W + QUO_W) ? PROD_W : SIZE_W + QUO_W;
  localparam int ADDR_W       = 2 * SIZE_W + 1;

  // Alpha arithmetic
  localparam int FULL_PROGRESS = 256;
  localparam int PROGRESS_GAIN = 510;
  localparam int GAIN_W        = PROG_W + 9;
  localparam int ALPHA_MAX     = 255;

  typedef logic [SIZE_W-1:0]     sz_t;
  typedef logic [PROG_W-1:0]     prog_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [QUO_W-1:0]      quo_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [TEXEL_W-1:0]    texel_t;
  typedef logic [ALPHA_W-1:0]    alpha_t;
  typedef logic [PROG_W-1:0]     lvl_t;
  typedef logic [GAIN_W-1:0]     gain_t;

  // Item kind carried on tuser
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_MASK_WIDTH     = 3'd0,
    CFG_MASK_HEIGHT    = 3'd1,
    CFG_SURFACE_WIDTH  = 3'd2,
    CFG_SURFACE_HEIGHT = 3'd3,
    CFG_PROGRESS       = 3'd4
  } cfg_idx_t;

  // Per-word tag carried down the pipe
  typedef struct packed {
    op_t                  op;
    logic [LD_ADDR_W-1:0] ld_addr;
    texel_t               ld_val;
  } tag_t;

  // Divider state for both axes
  typedef struct packed {
    prod_t rem_x;
    prod_t rem_y;
    quo_t  q_x;
    quo_t  q_y;
    logic  clamp_x;
    logic  clamp_y;
  } div_t;

endpackage

FILE: rtl/mta_ram.sv
// ----------------------------------------------------------------------------
// mta_ram: generic single-port RAM
// One access per cycle under enable; read data registered.
// ----------------------------------------------------------------------------
module mta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/mask_transition_alpha.sv
// ----------------------------------------------------------------------------
// mask_transition_alpha: rule-mask wipe transition alpha
// Maps surface pixels onto a loaded mask and returns the wipe alpha.
// ----------------------------------------------------------------------------
// Use:
//   Input words carry tuser = kind (0 load, 1 pixel). A load word writes one
//   mask texel and gives no output word; a pixel word gives one alpha word.
//   Pixel coordinates are scaled to the mask by x*mask_w/surface_w (and the
//   same for y) through a restoring divider of one quotient bit per stage,
//   then a mask address multiply, a mask read and the alpha compare.
//   Words pass the input, divider, clamp, address and mask read stages;
//   loads and pixels may be mixed freely and keep their order.
//   Throughput: one word per cycle unless stalled, set by the one-word-per-stage pipeline
//   and the single mask port (loads and reads use the same stage).
//   Stall: an output register plus one skid entry; in_tready drops as soon
//   as a word lands in the skid entry and the whole pipe holds until it
//   drains. in_tready is driven from a register.
//   Reset: synchronous, clears valid bits and sets sizes to 1 and progress to
//   0. The mask store is not cleared; pixels must only read written texels.
//   The user must write configuration on cfg_* only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module mask_transition_alpha (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mask_address[15:0], mask_value[23:16],
                                  // pixel_x[35:24], pixel_y[47:36]
  input  logic [0:0]  in_tuser,   // operation[0]
  // output word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // alpha[7:0]
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_data
);

  localparam int QuoW = mta_pkg::QUO_W;

  // Configuration registers (sizes stored with zero read as one)
  mta_pkg::sz_t   mw_r, mh_r, sw_r, sh_r;
  mta_pkg::prog_t prog_r;

  // Pipeline control
  logic en;

  // Stage A: input register
  logic           v_a_r;
  mta_pkg::tag_t  tag_a_r;
  mta_pkg::coord_t x_a_r, y_a_r;

  // Divider stages, index 0 holds the products
  logic          v_d_r   [QuoW+1];
  mta_pkg::tag_t tag_d_r [QuoW+1];
  mta_pkg::div_t div_d_r [QuoW+1];
  mta_pkg::div_t div_0;

  // Stage C: clamped mask coordinates
  logic          v_c_r;
  mta_pkg::tag_t tag_c_r;
  mta_pkg::sz_t  mx_c_r, my_c_r;

  // Stage E: linear address
  logic           v_e_r;
  logic           pix_e_r;
  mta_pkg::texel_t val_e_r;
  mta_pkg::addr_t addr_e_r;
  mta_pkg::addr_t addr_e_nxt;
  logic           inr_e;
  logic           ram_we;

  // Stage F: mask read data
  logic            v_f_r, pix_f_r, inr_f_r;
  mta_pkg::texel_t rdata;

  // Alpha
  mta_pkg::gain_t  gain_prod;
  mta_pkg::lvl_t   level, diff;
  mta_pkg::texel_t texel;
  mta_pkg::alpha_t alpha;
  logic            item_v;

  // Output register and skid entry
  logic            out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  mta_pkg::alpha_t out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  function automatic mta_pkg::sz_t nz_size(input mta_pkg::sz_t v);
    return (v == '0) ? mta_pkg::sz_t'(1) : v;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r   <= mta_pkg::sz_t'(1);
      mh_r   <= mta_pkg::sz_t'(1);
      sw_r   <= mta_pkg::sz_t'(1);
      sh_r   <= mta_pkg::sz_t'(1);
      prog_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        mta_pkg::CFG_MASK_WIDTH:     mw_r   <= nz_size(cfg_data);
        mta_pkg::CFG_MASK_HEIGHT:    mh_r   <= nz_size(cfg_data);
        mta_pkg::CFG_SURFACE_WIDTH:  sw_r   <= nz_size(cfg_data);
        mta_pkg::CFG_SURFACE_HEIGHT: sh_r   <= nz_size(cfg_data);
        mta_pkg::CFG_PROGRESS:       prog_r <= cfg_data[mta_pkg::PROG_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe moves while the skid entry is free
  assign en        = !skid_valid_r;
  assign in_tready = en;

  // Stage A: capture word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_a_r.op      <= mta_pkg::op_t'(in_tuser[0]);
      tag_a_r.ld_addr <= in_tdata[mta_pkg::LD_ADDR_LO +: mta_pkg::LD_ADDR_W];
      tag_a_r.ld_val  <= in_tdata[mta_pkg::LD_VAL_LO +: mta_pkg::TEXEL_W];
      x_a_r <= mta_pkg::coord_t'(in_tdata[mta_pkg::PIX_X_LO +: mta_pkg::PIXEL_W]);
      y_a_r <= mta_pkg::coord_t'(in_tdata[mta_pkg::PIX_Y_LO +: mta_pkg::PIXEL_W]);
    end
  end

  // Stage B: coordinate times mask size; clamp when coordinate >= surface size
  always_comb begin
    div_0.rem_x   = mta_pkg::prod_t'(x_a_r) * mta_pkg::prod_t'(mw_r);
    div_0.rem_y   = mta_pkg::prod_t'(y_a_r) * mta_pkg::prod_t'(mh_r);
    div_0.q_x     = '0;
    div_0.q_y     = '0;
    div_0.clamp_x = mta_pkg::cmp_t'(x_a_r) >= mta_pkg::cmp_t'(sw_r);
    div_0.clamp_y = mta_pkg::cmp_t'(y_a_r) >= mta_pkg::cmp_t'(sh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r[0] <= 1'b0;
    end else if (en) begin
      v_d_r[0] <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_d_r[0] <= tag_a_r;
      div_d_r[0] <= div_0;
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    localparam int Bit = QuoW - 1 - k;
    mta_pkg::div_t nxt;
    mta_pkg::cmp_t dvx, dvy;

    always_comb begin
      nxt = div_d_r[k];
      dvx = mta_pkg::cmp_t'(sw_r) << Bit;
      dvy = mta_pkg::cmp_t'(sh_r) << Bit;
      if (mta_pkg::cmp_t'(div_d_r[k].rem_x) >= dvx) begin
        nxt.rem_x    = mta_pkg::prod_t'(mta_pkg::cmp_t'(div_d_r[k].rem_x) - dvx);
        nxt.q_x[Bit] = 1'b1;
      end
      if (mta_pkg::cmp_t'(div_d_r[k].rem_y) >= dvy) begin
        nxt.rem_y    = mta_pkg::prod_t'(mta_pkg::cmp_t'(div_d_r[k].rem_y) - dvy);
        nxt.q_y[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_d_r[k+1] <= 1'b0;
      end else if (en) begin
        v_d_r[k+1] <= v_d_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_d_r[k+1] <= tag_d_r[k];
        div_d_r[k+1] <= nxt;
      end
    end
  end

  // Stage C: clamp to size - 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en) begin
      v_c_r <= v_d_r[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_c_r <= tag_d_r[QuoW];
      mx_c_r  <= div_d_r[QuoW].clamp_x ? mw_r - mta_pkg::sz_t'(1) : div_d_r[QuoW].q_x;
      my_c_r  <= div_d_r[QuoW].clamp_y ? mh_r - mta_pkg::sz_t'(1) : div_d_r[QuoW].q_y;
    end
  end

  // Stage E: row times width plus column, or the load address
  always_comb begin
    if (tag_c_r.op == mta_pkg::OP_PIXEL) begin
      addr_e_nxt = mta_pkg::addr_t'(mta_pkg::addr_t'(my_c_r) * mta_pkg::addr_t'(mw_r))
                 + mta_pkg::addr_t'(mx_c_r);
    end else begin
      addr_e_nxt = mta_pkg::addr_t'(tag_c_r.ld_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en) begin
      v_e_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_e_r  <= tag_c_r.op == mta_pkg::OP_PIXEL;
      val_e_r  <= tag_c_r.ld_val;
      addr_e_r <= addr_e_nxt;
    end
  end

  // Mask store access: loads write, pixels read, same stage keeps order
  assign inr_e  = addr_e_r < mta_pkg::addr_t'(mta_pkg::MASK_TEXELS);
  assign ram_we = v_e_r && !pix_e_r && inr_e;

  mta_ram #(
    .WIDTH (mta_pkg::TEXEL_W),
    .DEPTH (mta_pkg::MASK_TEXELS)
  ) u_mask (
    .clk   (clk),
    .en    (en),
    .we    (ram_we),
    .addr  (addr_e_r[mta_pkg::MASK_AW-1:0]),
    .wdata (val_e_r),
    .rdata (rdata)
  );

  // Stage F: read data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_f_r <= pix_e_r;
      inr_f_r <= inr_e;
    end
  end

  // Alpha = clamp(floor(510 * progress / 256) - texel, 0, 255)
  always_comb begin
    gain_prod = mta_pkg::gain_t'(mta_pkg::PROGRESS_GAIN) * mta_pkg::gain_t'(prog_r);
    level     = mta_pkg::lvl_t'(gain_prod >> 8);
    texel     = inr_f_r ? rdata : '0;
    diff      = level - mta_pkg::lvl_t'(texel);
    if (prog_r >= mta_pkg::prog_t'(mta_pkg::FULL_PROGRESS)) begin
      alpha = mta_pkg::alpha_t'(mta_pkg::ALPHA_MAX);
    end else if (level <= mta_pkg::lvl_t'(texel)) begin
      alpha = '0;
    end else if (diff > mta_pkg::lvl_t'(mta_pkg::ALPHA_MAX)) begin
      alpha = mta_pkg::alpha_t'(mta_pkg::ALPHA_MAX);
    end else begin
      alpha = diff[mta_pkg::ALPHA_W-1:0];
    end
  end

  // Output register with skid entry
  assign item_v = en && v_f_r && pix_f_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (item_v) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = alpha;
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = alpha;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held without an output word");

  a_quo_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r[QuoW] && tag_d_r[QuoW].op == mta_pkg::OP_PIXEL && !div_d_r[QuoW].clamp_x)
      |-> (div_d_r[QuoW].q_x < mw_r))
    else $error("x quotient out of mask range");

  a_quo_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_d_r[QuoW] && tag_d_r[QuoW].op == mta_pkg::OP_PIXEL && !div_d_r[QuoW].clamp_y)
      |-> (div_d_r[QuoW].q_y < mh_r))
    else $error("y quotient out of mask range");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("output word dropped while stalled");

endmodule
